/* sv/ilpt_pkg.sv */
package ilpt_pkg;

	// Input and result words
	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} ilpt_in_t;

	typedef struct packed {
		logic        is_valid;
		logic [2:0]  literal_type;
		logic [63:0] literal_value;
		logic [3:0]  byte_width;
	} ilpt_out_t;

	// Classified character, front to back
	typedef struct packed {
		logic       last;
		logic [3:0] dig_val;
		logic       is_dec;
		logic       is_oct;
		logic       is_hex;
		logic       is_x;
		logic       is_u;
		logic       is_l;
		logic       is_upper_l;
	} ilpt_cls_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_ZERO,
		PH_HEXPFX,
		PH_DIGITS,
		PH_AFTERU,
		PH_L1,
		PH_L2,
		PH_END
	} ilpt_phase_t;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} ilpt_base_t;

	// Type codes
	localparam logic [2:0] TYPE_INT    = 3'd0;
	localparam logic [2:0] TYPE_UINT   = 3'd1;
	localparam logic [2:0] TYPE_LONG   = 3'd2;
	localparam logic [2:0] TYPE_ULONG  = 3'd3;
	localparam logic [2:0] TYPE_LLONG  = 3'd4;
	localparam logic [2:0] TYPE_ULLONG = 3'd5;

	localparam logic [63:0] MAX_S32 = 64'h0000_0000_7fff_ffff;
	localparam logic [63:0] MAX_U32 = 64'h0000_0000_ffff_ffff;
	localparam logic [63:0] MAX_S64 = 64'h7fff_ffff_ffff_ffff;

	localparam int QUEUE_DEPTH = 2;

endpackage

/* sv/ilpt_front.sv */
module ilpt_front (
	input  ilpt_pkg::ilpt_in_t  char_word,
	input  logic                queue_full,
	output logic                front_ready,
	output ilpt_pkg::ilpt_cls_t cls
);
	import ilpt_pkg::*;

	logic [7:0] c;

	assign c = char_word.character;
	assign front_ready = !queue_full;

	// Character classes and digit value
	always_comb begin
		cls = '0;
		cls.last       = char_word.last_char;
		cls.is_dec     = (c inside {[8'h30:8'h39]});
		cls.is_oct     = (c inside {[8'h30:8'h37]});
		cls.is_hex     = (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
		cls.is_x       = (c == 8'h78) || (c == 8'h58);
		cls.is_u       = (c == 8'h75) || (c == 8'h55);
		cls.is_l       = (c == 8'h6c) || (c == 8'h4c);
		cls.is_upper_l = (c == 8'h4c);
		if (c inside {[8'h61:8'h66]}) begin
			cls.dig_val = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			cls.dig_val = 4'(c - 8'h37);
		end else begin
			cls.dig_val = c[3:0];
		end
	end

endmodule

/* sv/ilpt_queue.sv */
module ilpt_queue #(
	parameter int DEPTH = ilpt_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ilpt_pkg::ilpt_cls_t push_word,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output ilpt_pkg::ilpt_cls_t head_word
);
	import ilpt_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ilpt_cls_t         mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_word  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/ilpt_back.sv */
module ilpt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ilpt_pkg::ilpt_cls_t head_word,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output ilpt_pkg::ilpt_out_t res_word
);
	import ilpt_pkg::*;

	ilpt_phase_t phase_q, phase_d;
	ilpt_base_t  base_q, base_d, add_base;
	logic [63:0] acc_q, acc_d;
	logic        dseen_q, dseen_d;
	logic        err_q, err_d;
	logic        uns_q, uns_d;
	logic [1:0]  lcnt_q, lcnt_d;
	logic        lup_q, lup_d;
	logic        add_en;
	logic        sfx;
	logic        in_base;
	logic [68:0] wide;
	logic [68:0] scaled;
	logic [68:0] sum;
	logic        ovf;
	logic        fits;
	logic [2:0]  ltype;
	logic        dec;
	logic        out_valid_q;
	ilpt_out_t   out_word_q;
	ilpt_out_t   result;
	ilpt_cls_t   c;

	assign c = head_word;

	// Take a word unless it closes a token and the result slot is still full
	assign pop = head_valid && (!c.last || !out_valid_q || res_ready);

	assign in_base = (base_q == BASE_HEX) ? c.is_hex :
	                 (base_q == BASE_OCT) ? c.is_oct : c.is_dec;

	// Multiply by base and add digit, with carry-out for overflow
	always_comb begin
		wide = {5'b0, acc_q};
		case (add_base)
			BASE_HEX: scaled = wide << 4;
			BASE_OCT: scaled = wide << 3;
			default:  scaled = (wide << 3) + (wide << 1);
		endcase
		sum = scaled + {65'b0, c.dig_val};
		ovf = (sum[68:64] != '0);
	end

	// Parser next state
	always_comb begin
		phase_d  = phase_q;
		base_d   = base_q;
		acc_d    = acc_q;
		dseen_d  = dseen_q;
		err_d    = err_q;
		uns_d    = uns_q;
		lcnt_d   = lcnt_q;
		lup_d    = lup_q;
		add_en   = 1'b0;
		add_base = base_q;
		sfx      = 1'b0;
		if (!err_q) begin
			case (phase_q)
				PH_START: begin
					if (c.is_dec && c.dig_val == 4'd0) begin
						base_d  = BASE_OCT;
						dseen_d = 1'b1;
						phase_d = PH_ZERO;
					end else if (c.is_dec) begin
						base_d   = BASE_DEC;
						add_base = BASE_DEC;
						add_en   = 1'b1;
						phase_d  = PH_DIGITS;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_ZERO: begin
					if (c.is_x) begin
						base_d  = BASE_HEX;
						dseen_d = 1'b0;
						phase_d = PH_HEXPFX;
					end else if (c.is_dec && !c.is_oct) begin
						err_d = 1'b1;
					end else if (c.is_oct) begin
						add_en  = 1'b1;
						phase_d = PH_DIGITS;
					end else begin
						sfx = 1'b1;
					end
				end
				PH_HEXPFX: begin
					if (c.is_hex) begin
						add_en  = 1'b1;
						phase_d = PH_DIGITS;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (base_q == BASE_OCT && c.is_dec && !c.is_oct) begin
						err_d = 1'b1;
					end else if (in_base) begin
						add_en = 1'b1;
					end else begin
						sfx = 1'b1;
					end
				end
				default: sfx = 1'b1;
			endcase
		end

		if (add_en) begin
			if (ovf) begin
				err_d = 1'b1;
			end else begin
				acc_d   = sum[63:0];
				dseen_d = 1'b1;
			end
		end

		// Suffix letters
		if (sfx) begin
			case (phase_q)
				PH_ZERO, PH_DIGITS: begin
					if (c.is_u) begin
						uns_d   = 1'b1;
						phase_d = PH_AFTERU;
					end else if (c.is_l) begin
						lcnt_d  = 2'd1;
						lup_d   = c.is_upper_l;
						phase_d = PH_L1;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_AFTERU: begin
					if (c.is_l) begin
						lcnt_d  = 2'd1;
						lup_d   = c.is_upper_l;
						phase_d = PH_L1;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_L1: begin
					if (c.is_l && c.is_upper_l == lup_q) begin
						lcnt_d  = 2'd2;
						phase_d = PH_L2;
					end else if (c.is_u && !uns_q) begin
						uns_d   = 1'b1;
						phase_d = PH_END;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_L2: begin
					if (c.is_u && !uns_q) begin
						uns_d   = 1'b1;
						phase_d = PH_END;
					end else begin
						err_d = 1'b1;
					end
				end
				default: err_d = 1'b1;
			endcase
		end
	end

	// Type choice in the standard candidate order
	always_comb begin
		dec   = (base_d == BASE_DEC);
		fits  = 1'b1;
		ltype = TYPE_INT;
		if (uns_d) begin
			if (lcnt_d == 2'd0 && acc_d <= MAX_U32) begin
				ltype = TYPE_UINT;
			end else if (lcnt_d <= 2'd1) begin
				ltype = TYPE_ULONG;
			end else begin
				ltype = TYPE_ULLONG;
			end
		end else if (lcnt_d == 2'd0 && acc_d <= MAX_S32) begin
			ltype = TYPE_INT;
		end else if (lcnt_d == 2'd0 && !dec && acc_d <= MAX_U32) begin
			ltype = TYPE_UINT;
		end else if (lcnt_d <= 2'd1) begin
			if (acc_d <= MAX_S64) begin
				ltype = TYPE_LONG;
			end else if (!dec) begin
				ltype = TYPE_ULONG;
			end else begin
				fits = 1'b0;
			end
		end else begin
			if (acc_d <= MAX_S64) begin
				ltype = TYPE_LLONG;
			end else if (!dec) begin
				ltype = TYPE_ULLONG;
			end else begin
				fits = 1'b0;
			end
		end

		result = '0;
		if (!err_d && dseen_d && phase_d != PH_START && phase_d != PH_HEXPFX && fits) begin
			result.is_valid      = 1'b1;
			result.literal_type  = ltype;
			result.literal_value = acc_d;
			result.byte_width    = (ltype <= TYPE_UINT) ? 4'd4 : 4'd8;
		end
	end

	// Parser state; back to start after each closing character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			base_q  <= BASE_DEC;
			acc_q   <= '0;
			dseen_q <= 1'b0;
			err_q   <= 1'b0;
			uns_q   <= 1'b0;
			lcnt_q  <= '0;
			lup_q   <= 1'b0;
		end else if (pop) begin
			if (c.last) begin
				phase_q <= PH_START;
				base_q  <= BASE_DEC;
				acc_q   <= '0;
				dseen_q <= 1'b0;
				err_q   <= 1'b0;
				uns_q   <= 1'b0;
				lcnt_q  <= '0;
				lup_q   <= 1'b0;
			end else begin
				phase_q <= phase_d;
				base_q  <= base_d;
				acc_q   <= acc_d;
				dseen_q <= dseen_d;
				err_q   <= err_d;
				uns_q   <= uns_d;
				lcnt_q  <= lcnt_d;
				lup_q   <= lup_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && c.last) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && c.last) begin
			out_word_q <= result;
		end
	end

	assign res_valid = out_valid_q;
	assign res_word  = out_word_q;

endmodule

/* sv/integer_literal_parse_and_type_unit.sv */
// A result word is valid in the cycle after its closing character is taken from
//   the front-to-back queue.
// Throughput: one character word per cycle while the queue is not full; the parser
//   step (multiply by base, add, carry-out check) is combinational.
// Reset: arst_n clears the queue, the parser state and the result valid flag.
module integer_literal_parse_and_type_unit #(
	parameter int QUEUE_DEPTH = ilpt_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  ilpt_pkg::ilpt_in_t  char_word,
	output logic                res_valid,
	input  logic                res_ready,
	output ilpt_pkg::ilpt_out_t res_word
);
	import ilpt_pkg::*;

	ilpt_cls_t cls;
	ilpt_cls_t head_word;
	logic      queue_full;
	logic      head_valid;
	logic      pop;

	// Classifier
	ilpt_front u_front (
		.char_word   (char_word),
		.queue_full  (queue_full),
		.front_ready (char_ready),
		.cls         (cls)
	);

	// Queue between the two parts
	ilpt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (char_valid),
		.push_word  (cls),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_word  (head_word)
	);

	// Parser and result register
	ilpt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_word   (res_word)
	);

endmodule
